// File: src/prf_pkg.sv
package prf_pkg;

	localparam int COORD_W = 6;
	localparam int OP_W    = 3;
	localparam int RADDR_W = 13;
	localparam int COLOR_W = 12;
	localparam int DATA_W  = 8;

	localparam logic [OP_W-1:0] OP_POINT = 3'd0;
	localparam logic [OP_W-1:0] OP_HLINE = 3'd1;
	localparam logic [OP_W-1:0] OP_VLINE = 3'd2;
	localparam logic [OP_W-1:0] OP_RECT  = 3'd3;
	localparam logic [OP_W-1:0] OP_READ  = 3'd4;

	// register index sits in paddr[2]
	localparam logic REG_FILL_COLOR = 1'b0;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_ROW,
		ST_PIX_A,
		ST_PIX_B,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [3:0] red;
		logic [3:0] green;
		logic [3:0] blue;
	} color_t;

endpackage

// File: src/prf_if.sv
interface prf_cmd_if;
	import prf_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      opcode;
	logic [COORD_W-1:0]   x_start;
	logic [COORD_W-1:0]   y_start;
	logic [COORD_W-1:0]   x_end;
	logic [COORD_W-1:0]   y_end;
	logic [RADDR_W-1:0]   read_address;

	modport source (output valid, opcode, x_start, y_start, x_end, y_end, read_address,
		input ready);
	modport sink (input valid, opcode, x_start, y_start, x_end, y_end, read_address,
		output ready);
endinterface

interface prf_rsp_if;
	import prf_pkg::*;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;
	logic              rejected;

	modport source (output valid, read_data, rejected, input ready);
	modport sink (input valid, read_data, rejected, output ready);
endinterface

// File: src/prf_ram.sv
module prf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/packed_rgb444_rect_fill.sv
// A read passes ST_READ and ST_FINISH before its reply word is registered; a rejected or
// unused command goes from ST_IDLE straight to ST_FINISH. Each shape pixel is written in
// ST_PIX_A (full byte), then ST_PIX_B (read-merge-write of the shared byte), and each row
// first passes ST_ROW for the row-base multiply; one command at a time. Throughput is bounded
// by the single-write-port frame RAM: at most one byte written per cycle. Reset: fill color
// clears to zero, then a clearing pass zeroes every store byte with cmd.ready low.
module packed_rgb444_rect_fill #(
	parameter int FRAME_WIDTH  = 64,
	parameter int FRAME_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	prf_cmd_if.sink     cmd,
	prf_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import prf_pkg::*;

	localparam int PIXELS      = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int NIBBLES     = 3 * PIXELS;
	localparam int STORE_BYTES = (NIBBLES + 1) / 2;
	localparam int PW          = $clog2(PIXELS);
	localparam int NW          = $clog2(NIBBLES);
	localparam int AW          = $clog2(STORE_BYTES);

	state_t state_q, state_d;

	color_t             color_q;
	logic [AW-1:0]      clr_q;
	logic [COORD_W-1:0] x_q, y_q, x0_q, x1_q, y1_q;
	logic [PW-1:0]      rowbase_q;
	logic               pend_even_q;
	logic               pend_en_q;
	logic [AW-1:0]      pend_addr_q;
	logic               rd_ok_q;
	logic [DATA_W-1:0]  res_data_q;
	logic               res_rej_q;
	logic               rsp_valid_q;
	logic [DATA_W-1:0]  rsp_data_q;
	logic               rsp_rej_q;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [DATA_W-1:0]  ram_wdata;
	logic [AW-1:0]      ram_raddr;
	logic [DATA_W-1:0]  ram_rdata;

	logic [PW-1:0]      pix;
	logic [NW-1:0]      nib;
	logic [AW-1:0]      base;
	logic               even;
	logic [AW-1:0]      full_addr;
	logic [AW-1:0]      part_addr;
	logic               in_frame;
	logic               cmd_rej;
	logic               cfg_wr;
	logic               rsp_load;

	// pixel address: nibble offset 3*p, byte = nibble/2
	assign pix       = rowbase_q + PW'(x_q);
	assign nib       = NW'(pix) + NW'({pix, 1'b0});
	assign base      = AW'(nib >> 1);
	assign even      = ~pix[0];
	assign full_addr = even ? base : base + 1'b1;
	assign part_addr = even ? base + 1'b1 : base;
	assign in_frame  = (32'(x_q) < FRAME_WIDTH) && (32'(y_q) < FRAME_HEIGHT);

	assign cmd_rej = ((cmd.opcode == OP_HLINE) && (cmd.x_end < cmd.x_start))
		|| ((cmd.opcode == OP_VLINE) && (cmd.y_end < cmd.y_start))
		|| ((cmd.opcode == OP_RECT)
			&& ((cmd.x_end < cmd.x_start) || (cmd.y_end < cmd.y_start)));

	assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_FILL_COLOR);
	assign rsp_load = (state_q == ST_FINISH) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		state_d   = state_q;
		cmd.ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = full_addr;
		ram_wdata = '0;
		ram_raddr = part_addr;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				if (clr_q == AW'(STORE_BYTES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.ready = 1'b1;
				ram_raddr = AW'(cmd.read_address);
				if (cmd.valid) begin
					if (cmd.opcode == OP_READ) begin
						state_d = ST_READ;
					end else if (cmd_rej || cmd.opcode > OP_RECT) begin
						state_d = ST_FINISH;
					end else begin
						state_d = ST_ROW;
					end
				end
			end
			ST_READ: begin
				state_d = ST_FINISH;
			end
			ST_ROW: begin
				state_d = ST_PIX_A;
			end
			ST_PIX_A: begin
				ram_we    = in_frame;
				ram_wdata = even ? {color_q.red, color_q.green}
					: {color_q.green, color_q.blue};
				state_d   = ST_PIX_B;
			end
			ST_PIX_B: begin
				// merge the pixel's nibble into the byte shared with its neighbor
				ram_we    = pend_en_q;
				ram_waddr = pend_addr_q;
				ram_wdata = pend_even_q ? {color_q.blue, ram_rdata[3:0]}
					: {ram_rdata[7:4], color_q.red};
				if (x_q == x1_q) begin
					state_d = (y_q == y1_q) ? ST_FINISH : ST_ROW;
				end else begin
					state_d = ST_PIX_A;
				end
			end
			ST_FINISH: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			color_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_wr) begin
				color_q <= color_t'(pwdata[COLOR_W-1:0]);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd.valid) begin
			x_q        <= cmd.x_start;
			y_q        <= cmd.y_start;
			x0_q       <= cmd.x_start;
			x1_q       <= (cmd.opcode == OP_HLINE || cmd.opcode == OP_RECT)
				? cmd.x_end : cmd.x_start;
			y1_q       <= (cmd.opcode == OP_VLINE || cmd.opcode == OP_RECT)
				? cmd.y_end : cmd.y_start;
			res_rej_q  <= cmd_rej;
			res_data_q <= '0;
			rd_ok_q    <= 32'(cmd.read_address) < STORE_BYTES;
		end
		if (state_q == ST_READ) begin
			res_data_q <= rd_ok_q ? ram_rdata : '0;
		end
		if (state_q == ST_ROW) begin
			rowbase_q <= PW'(32'(y_q) * FRAME_WIDTH);
		end
		if (state_q == ST_PIX_A) begin
			pend_even_q <= even;
			pend_addr_q <= part_addr;
			pend_en_q   <= in_frame;
		end
		if (state_q == ST_PIX_B) begin
			// advance column, wrap to next row
			if (x_q == x1_q) begin
				x_q <= x0_q;
				y_q <= y_q + 1'b1;
			end else begin
				x_q <= x_q + 1'b1;
			end
		end
		if (rsp_load) begin
			rsp_data_q <= res_data_q;
			rsp_rej_q  <= res_rej_q;
		end
	end

	prf_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STORE_BYTES)
	) u_frame_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rsp.valid     = rsp_valid_q;
	assign rsp.read_data = rsp_data_q;
	assign rsp.rejected  = rsp_rej_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FILL_COLOR) ? {{(32 - COLOR_W){1'b0}}, color_q} : '0;

endmodule

// File: tb/sv/packed_rgb444_rect_fill_tb.sv
`timescale 1ns / 100ps

module packed_rgb444_rect_fill_tb;
	import prf_pkg::*;

	localparam int FRAME_W         = 64;
	localparam int FRAME_H         = 64;
	localparam int STORE_BYTES     = (FRAME_W * FRAME_H * 3 + 1) / 2;
	localparam int COORD_MAX       = (1 << COORD_W) - 1;
	localparam int OP_LAST         = (1 << OP_W) - 1;
	localparam int LONG_HOLD       = 400;
	localparam int RANDOM_PHASES   = 6;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int BIG_RECT_MAX    = 3;

	localparam logic [2:0] ADDR_FILL_COLOR = {REG_FILL_COLOR, 2'b00};
	localparam logic [2:0] ADDR_SPARE_REG  = {~REG_FILL_COLOR, 2'b00};

	typedef struct packed {
		logic [OP_W-1:0]    opcode;
		logic [COORD_W-1:0] x_start;
		logic [COORD_W-1:0] y_start;
		logic [COORD_W-1:0] x_end;
		logic [COORD_W-1:0] y_end;
		logic [RADDR_W-1:0] read_address;
	} draw_cmd_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              rejected;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	prf_cmd_if cmd_bus ();
	prf_rsp_if rsp_bus ();

	packed_rgb444_rect_fill #(
		.FRAME_WIDTH (FRAME_W),
		.FRAME_HEIGHT(FRAME_H)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.rsp    (rsp_bus),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	always #2 clk = ~clk;

	// frame model and its fill color
	logic [7:0] frame_bytes [0:STORE_BYTES-1];
	color_t     fill_rgb;

	draw_cmd_t draw_cmds[$];
	reply_t    expected_replies[$];
	draw_cmd_t live_cmd;

	int error_count = 0;
	int burst_left;
	int gap_left;
	int hold_off_requests = 0;
	int hold_off_served = 0;
	int hold_left;
	int stall_mode;
	int segment_left;
	int last_x = 0;
	int last_y = 0;
	int big_rects = 0;

	function automatic int pixel_byte(int x, int y);
		return ((y * FRAME_W + x) * 3) >> 1;
	endfunction

	function automatic void set_nibble(int k, logic [3:0] v);
		int b;
		b = k >> 1;
		if (b >= STORE_BYTES)
			return;
		if (k[0] == 1'b0)
			frame_bytes[b][7:4] = v;
		else
			frame_bytes[b][3:0] = v;
	endfunction

	function automatic void paint_pixel(int x, int y);
		int n;
		if (x >= FRAME_W || y >= FRAME_H)
			return;
		n = (y * FRAME_W + x) * 3;
		set_nibble(n, fill_rgb.red);
		set_nibble(n + 1, fill_rgb.green);
		set_nibble(n + 2, fill_rgb.blue);
	endfunction

	function automatic void fill_area(int x0, int y0, int x1, int y1);
		for (int y = y0; y <= y1; y++)
			for (int x = x0; x <= x1; x++)
				paint_pixel(x, y);
	endfunction

	// draw into the frame model and queue the reply the block owes
	function automatic void render_cmd(draw_cmd_t c);
		reply_t r;
		r = '0;
		case (c.opcode)
			OP_POINT: paint_pixel(c.x_start, c.y_start);
			OP_HLINE: begin
				if (c.x_end < c.x_start)
					r.rejected = 1'b1;
				else
					fill_area(c.x_start, c.y_start, c.x_end, c.y_start);
			end
			OP_VLINE: begin
				if (c.y_end < c.y_start)
					r.rejected = 1'b1;
				else
					fill_area(c.x_start, c.y_start, c.x_start, c.y_end);
			end
			OP_RECT: begin
				if (c.x_end < c.x_start || c.y_end < c.y_start)
					r.rejected = 1'b1;
				else
					fill_area(c.x_start, c.y_start, c.x_end, c.y_end);
			end
			OP_READ: begin
				if (c.read_address < STORE_BYTES)
					r.read_data = frame_bytes[c.read_address];
			end
			default: ;
		endcase
		expected_replies.push_back(r);
	endfunction

	function automatic void queue_cmd(logic [OP_W-1:0] op, int xs, int ys, int xe, int ye,
		int addr);
		draw_cmd_t c;
		c.opcode       = op;
		c.x_start      = COORD_W'(xs);
		c.y_start      = COORD_W'(ys);
		c.x_end        = COORD_W'(xe);
		c.y_end        = COORD_W'(ye);
		c.read_address = RADDR_W'(addr);
		draw_cmds.push_back(c);
	endfunction

	function automatic draw_cmd_t random_cmd();
		draw_cmd_t c;
		int pick;
		int span_x;
		int span_y;
		int t;
		c.opcode       = OP_W'($urandom);
		c.x_start      = COORD_W'($urandom);
		c.y_start      = COORD_W'($urandom);
		c.x_end        = COORD_W'($urandom);
		c.y_end        = COORD_W'($urandom);
		c.read_address = RADDR_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 28) begin
			c.opcode = OP_READ;
			// mostly read back bytes near the last drawn shape
			if ($urandom_range(0, 7) != 0)
				c.read_address = RADDR_W'(pixel_byte(last_x + $urandom_range(0, 3), last_y)
					+ $urandom_range(0, 2));
		end else if (pick < 31) begin
			c.opcode = OP_W'($urandom_range(OP_READ + 1, OP_LAST));
		end else begin
			c.opcode = OP_W'($urandom_range(OP_POINT, OP_RECT));
			span_x = ($urandom_range(0, 24) == 0) ? $urandom_range(0, COORD_MAX)
				: $urandom_range(0, 7);
			span_y = ($urandom_range(0, 24) == 0) ? $urandom_range(0, COORD_MAX)
				: $urandom_range(0, 7);
			// keep full-size rectangles rare, they are slow to draw
			if (c.opcode == OP_RECT && span_x * span_y > 256) begin
				if (big_rects >= BIG_RECT_MAX)
					span_y = 2;
				else
					big_rects++;
			end
			c.x_start = COORD_W'($urandom_range(0, COORD_MAX - span_x));
			c.y_start = COORD_W'($urandom_range(0, COORD_MAX - span_y));
			c.x_end   = COORD_W'(c.x_start + span_x);
			c.y_end   = COORD_W'(c.y_start + span_y);
			last_x = c.x_start;
			last_y = c.y_start;
			if (c.opcode == OP_POINT) begin
				c.x_end = COORD_W'($urandom);
				c.y_end = COORD_W'($urandom);
			end else if ($urandom_range(0, 15) == 0) begin
				// swap ends to provoke a rejection
				if (c.opcode == OP_HLINE || (c.opcode == OP_RECT && $urandom_range(0, 1))) begin
					t = c.x_start;
					c.x_start = c.x_end;
					c.x_end = COORD_W'(t);
				end
				if (c.opcode == OP_VLINE || (c.opcode == OP_RECT && $urandom_range(0, 1))) begin
					t = c.y_start;
					c.y_start = c.y_end;
					c.y_end = COORD_W'(t);
				end
			end
		end
		return c;
	endfunction

	task automatic write_reg(logic [2:0] addr, logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr[2] == REG_FILL_COLOR)
			fill_rgb = data[COLOR_W-1:0];
	endtask

	// sample on the falling edge so the driver's updates have settled
	task automatic wait_drained();
		while (draw_cmds.size() != 0 || cmd_bus.valid || expected_replies.size() != 0)
			@(negedge clk);
	endtask

	// command driver: bursts of words with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_bus.valid        <= 1'b0;
			cmd_bus.opcode       <= '0;
			cmd_bus.x_start      <= '0;
			cmd_bus.y_start      <= '0;
			cmd_bus.x_end        <= '0;
			cmd_bus.y_end        <= '0;
			cmd_bus.read_address <= '0;
			burst_left = 1;
			gap_left = 0;
		end else begin
			if (cmd_bus.valid && cmd_bus.ready)
				render_cmd(live_cmd);
			if (!cmd_bus.valid || cmd_bus.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					cmd_bus.valid <= 1'b0;
				end else if (draw_cmds.size() != 0) begin
					live_cmd = draw_cmds.pop_front();
					cmd_bus.valid        <= 1'b1;
					cmd_bus.opcode       <= live_cmd.opcode;
					cmd_bus.x_start      <= live_cmd.x_start;
					cmd_bus.y_start      <= live_cmd.y_start;
					cmd_bus.x_end        <= live_cmd.x_end;
					cmd_bus.y_end        <= live_cmd.y_end;
					cmd_bus.read_address <= live_cmd.read_address;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					cmd_bus.valid <= 1'b0;
				end
			end
		end
	end

	// reply receiver: stall pattern changes per segment, long hold on request
	always @(posedge clk or negedge arst_n) begin : reply_ready
		logic take;
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
			hold_left = 0;
			stall_mode = 0;
			segment_left = 0;
		end else begin
			if (hold_off_requests != hold_off_served) begin
				hold_off_served = hold_off_requests;
				hold_left = LONG_HOLD;
			end
			if (segment_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				segment_left = $urandom_range(20, 200);
			end else begin
				segment_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				take = 1'b0;
			end else begin
				case (stall_mode)
					0: take = 1'b1;
					1: take = 1'($urandom_range(0, 1));
					2: take = ($urandom_range(0, 3) == 0);
					default: take = ~rsp_bus.ready;
				endcase
			end
			rsp_bus.ready <= take;
		end
	end

	always @(posedge clk) begin : check_replies
		reply_t want;
		if (arst_n === 1'b1 && rsp_bus.valid && rsp_bus.ready) begin
			if (expected_replies.size() == 0) begin
				$error("reply word with nothing expected: read_data %0h rejected %0b",
					rsp_bus.read_data, rsp_bus.rejected);
				error_count++;
			end else begin
				want = expected_replies.pop_front();
				if (rsp_bus.read_data !== want.read_data) begin
					$error("read_data: expected %0h, got %0h", want.read_data, rsp_bus.read_data);
					error_count++;
				end
				if (rsp_bus.rejected !== want.rejected) begin
					$error("rejected: expected %0b, got %0b", want.rejected, rsp_bus.rejected);
					error_count++;
				end
			end
		end
	end

	initial begin : stimulus
		logic [COLOR_W-1:0] color;
		arst_n               = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		cmd_bus.valid        = 1'b0;
		cmd_bus.opcode       = '0;
		cmd_bus.x_start      = '0;
		cmd_bus.y_start      = '0;
		cmd_bus.x_end        = '0;
		cmd_bus.y_end        = '0;
		cmd_bus.read_address = '0;
		rsp_bus.ready        = 1'b0;
		fill_rgb             = '0;
		for (int i = 0; i < STORE_BYTES; i++)
			frame_bytes[i] = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// distinct nibbles expose any merge slip in shared bytes
		write_reg(ADDR_FILL_COLOR, {20'($urandom), 12'hA5C});
		queue_cmd(OP_READ, 0, 0, 0, 0, 0);
		queue_cmd(OP_POINT, 0, 0, 0, 0, 0);
		queue_cmd(OP_POINT, 1, 0, 0, 0, 0);
		queue_cmd(OP_READ, 0, 0, 0, 0, 0);
		queue_cmd(OP_READ, 0, 0, 0, 0, 1);
		queue_cmd(OP_READ, 0, 0, 0, 0, 2);
		queue_cmd(OP_POINT, COORD_MAX, COORD_MAX, 0, 0, 0);
		queue_cmd(OP_READ, 0, 0, 0, 0, pixel_byte(COORD_MAX, COORD_MAX));
		queue_cmd(OP_READ, 0, 0, 0, 0, pixel_byte(COORD_MAX, COORD_MAX) + 1);
		queue_cmd(OP_READ, 0, 0, 0, 0, STORE_BYTES);
		queue_cmd(OP_READ, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, (1 << RADDR_W) - 1);
		queue_cmd(OP_HLINE, 0, 1, COORD_MAX, 0, 0);
		queue_cmd(OP_READ, 0, 0, 0, 0, pixel_byte(0, 1));
		queue_cmd(OP_VLINE, COORD_MAX, 0, 0, COORD_MAX, 0);
		queue_cmd(OP_RECT, 10, 20, 12, 22, 0);
		queue_cmd(OP_READ, 0, 0, 0, 0, pixel_byte(11, 22));
		queue_cmd(OP_HLINE, 5, 3, 4, 3, 0);
		queue_cmd(OP_VLINE, 7, COORD_MAX, 7, 0, 0);
		queue_cmd(OP_RECT, 9, 0, 8, COORD_MAX, 0);
		queue_cmd(OP_RECT, 0, 9, COORD_MAX, 8, 0);
		queue_cmd(OP_RECT, COORD_MAX, COORD_MAX, 0, 0, 0);
		for (int op = OP_READ + 1; op <= OP_LAST; op++)
			queue_cmd(OP_W'(op), COORD_MAX, 1, 2, COORD_MAX, 3);
		// a point ignores its end fields
		queue_cmd(OP_POINT, 2, 2, 0, 0, 0);
		queue_cmd(OP_READ, 0, 0, 0, 0, pixel_byte(2, 2));
		wait_drained();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: color = '1;
				2: color = '0;
				default: color = COLOR_W'($urandom);
			endcase
			write_reg(ADDR_FILL_COLOR, {20'($urandom), color});
			if (phase == 3)
				write_reg(ADDR_SPARE_REG, $urandom);
			if (phase == 0)
				queue_cmd(OP_RECT, 0, 0, COORD_MAX, COORD_MAX, 0);
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				draw_cmds.push_back(random_cmd());
			// hold replies off while commands keep coming
			if (phase == 1)
				hold_off_requests++;
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: filelist.f
src/prf_pkg.sv
src/prf_if.sv
src/prf_ram.sv
src/packed_rgb444_rect_fill.sv
tb/sv/packed_rgb444_rect_fill_tb.sv
